>>> design/pwpw_pkg.sv
// ----------------------------------------------------------------------------
// Pulse width to wiper mapper: shared package
// Types, codes, constants and the symbol centre table used by the modules of
// the pulse width to wiper mapper.
// ----------------------------------------------------------------------------
package pwpw_pkg;

  // Symbol centre table for the seven-bit pot.
  localparam int unsigned TableLen           = 18;
  localparam int unsigned SymbolCountDefault = 18;
  localparam int unsigned CenterBase         = 1024;
  localparam int unsigned CenterStep         = 56;

  localparam logic [6:0] CenterTable [TableLen] = '{
    7'd5,  7'd12, 7'd19, 7'd26, 7'd33,  7'd40,  7'd47,  7'd53,  7'd60,
    7'd67, 7'd74, 7'd81, 7'd87, 7'd94, 7'd101, 7'd108, 7'd115, 7'd122
  };

  // Divider widths: magnitude of the scaled offset and of the width span.
  localparam int unsigned NumWidth = 26;
  localparam int unsigned DenWidth = 16;

  typedef enum logic [1:0] {
    OP_SET_WIDTH = 2'd0,
    OP_SET_RAW   = 2'd1,
    OP_ACK       = 2'd2,
    OP_REAPPLY   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_DISABLED = 2'd1,
    STAT_WAIT_ACK = 2'd2,
    STAT_FAILED   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_POT_TYPE     = 3'd0,
    REG_MIN_WIDTH    = 3'd1,
    REG_MAX_WIDTH    = 3'd2,
    REG_MIN_POSITION = 3'd3,
    REG_MAX_POSITION = 3'd4,
    REG_BUS_ADDRESS  = 3'd5,
    REG_ENABLED      = 3'd6
  } reg_index_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] width_request;
    logic [9:0]  raw_position;
    logic        ack_ok;
  } in_item_t;

  typedef struct packed {
    logic        write_needed;
    logic [6:0]  frame_address;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [1:0]  status;
    logic [8:0]  position_now;
    logic        position_known;
    logic [15:0] width_now;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] data;
  } cfg_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clamp;
    logic map;
    logic div_start;
    logic finish;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_status_t;

  // True when the width is one of the first count symbol centres.
  function automatic logic center_hit(input logic [15:0] w, input int unsigned count);
    logic hit;
    hit = 1'b0;
    for (int unsigned k = 0; k < TableLen; k++) begin
      if ((k < count) && (w == 16'(CenterBase + CenterStep * k))) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // Table entry for a width that sits on a symbol centre.
  function automatic logic [6:0] center_value(input logic [15:0] w);
    logic [6:0] val;
    val = '0;
    for (int unsigned k = 0; k < TableLen; k++) begin
      if (w == 16'(CenterBase + CenterStep * k)) begin
        val = CenterTable[k];
      end
    end
    return val;
  endfunction

endpackage

>>> design/pwpw_chan_if.sv
// ----------------------------------------------------------------------------
// Pulse width to wiper mapper: valid/ready channel
// One request channel with valid, ready and a payload of a given type.
// ----------------------------------------------------------------------------
interface pwpw_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> design/pulse_width_to_pot_wiper_unit.sv
// ----------------------------------------------------------------------------
// Pulse width to wiper mapper: top level
// Turns servo pulse widths into digital pot wiper positions and write frames.
//
// Channels: in_i takes requests (set width, set raw wiper, acknowledge report,
// reapply stored width); out_o gives one result per request; cfg_i writes the
// configuration registers by index and is always ready. Configuration must be
// written only while no request is in flight; the block does not enforce this.
// A request passes through capture, clamp, map, an optional divide, finish and
// hand-over; only a width that goes through the linear map with unequal
// calibration widths uses the one-bit-per-cycle divider (26 steps).
// One request is worked on at a time; the next is accepted as soon as the
// previous result has moved into the output register, so one finished result
// can wait there while the next request is processed. If the receiver stalls
// with a second result ready, the block holds that result and accepts nothing.
// Reset clears the wiper state, loads the register defaults and stores a
// width of 1500 us; the output register comes up empty.
// ----------------------------------------------------------------------------
module pulse_width_to_pot_wiper_unit #(
  parameter int unsigned SYMBOL_COUNT = pwpw_pkg::SymbolCountDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pwpw_chan_if.sink    in_i,
  pwpw_chan_if.source  out_o,
  pwpw_chan_if.sink    cfg_i
);
  import pwpw_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;
  out_item_t  out_item;

  // Configuration writes are taken in any cycle.
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  // Sequencer.
  pwpw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Registers, arithmetic and output stage.
  pwpw_dp #(
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_i.payload),
    .cfg_valid_i (cfg_i.valid),
    .cfg_item_i  (cfg_i.payload),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_item)
  );

  assign out_o.valid   = out_valid;
  assign out_o.payload = out_item;

endmodule

>>> design/pwpw_div.sv
// ----------------------------------------------------------------------------
// Pulse width to wiper mapper: restoring divider
// Unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwpw_div #(
  parameter int unsigned NumW = 26,
  parameter int unsigned DenW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] dividend_i,
  input  logic [DenW-1:0] divisor_i,
  output logic [NumW-1:0] quotient_o,
  output logic            done_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [DenW-1:0] rem_q;
  logic [NumW-1:0] quo_q;
  logic [DenW-1:0] div_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic            fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_q, quo_q[NumW-1]};
    diff  = trial - {1'b0, div_q};
    fits  = (trial >= {1'b0, div_q});
  end

  // Sequencing of the iterations.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(NumW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DenW-1:0] : trial[DenW-1:0];
      quo_q <= {quo_q[NumW-2:0], fits};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

>>> design/pwpw_dp.sv
// ----------------------------------------------------------------------------
// Pulse width to wiper mapper: datapath
// Configuration registers, wiper state, linear map with divider, frame
// formatting and the output register.
// ----------------------------------------------------------------------------
module pwpw_dp #(
  parameter int unsigned SYMBOL_COUNT = pwpw_pkg::SymbolCountDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pwpw_pkg::in_item_t   in_item_i,
  input  logic                 cfg_valid_i,
  input  pwpw_pkg::cfg_item_t  cfg_item_i,
  input  pwpw_pkg::ctrl_cmd_t  cmd_i,
  output pwpw_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pwpw_pkg::out_item_t  out_item_o
);
  import pwpw_pkg::*;

  // Configuration.
  logic        pot_type_q;
  logic [15:0] min_width_q;
  logic [15:0] max_width_q;
  logic [8:0]  min_pos_q;
  logic [8:0]  max_pos_q;
  logic [6:0]  bus_addr_q;
  logic        enabled_q;

  // Wiper state.
  logic [8:0]  committed_q, committed_d;
  logic        known_q, known_d;
  logic [8:0]  pend_pos_q, pend_pos_d;
  logic        pend_valid_q, pend_valid_d;
  logic [15:0] stored_q;
  logic        good_q, good_d;

  // Working registers.
  in_item_t           in_q;
  logic signed [26:0] prod_q;
  logic signed [16:0] den_q;
  logic               hit_q;
  logic [6:0]         tval_q;
  out_item_t          res_q, res_d;
  out_item_t          out_q;
  logic               out_valid_q;

  logic               width_op;
  logic [15:0]        w_sel;
  logic [15:0]        x;
  logic signed [16:0] dx;
  logic signed [9:0]  dpos;
  logic [NumWidth-1:0] num_mag;
  logic [DenWidth-1:0] den_mag;
  logic [NumWidth-1:0] quo;
  logic               div_done;
  logic               neg;
  logic signed [27:0] q_signed;
  logic signed [27:0] r_lin;
  logic [8:0]         dev_max;
  logic [8:0]         p_lin;
  logic [8:0]         p_raw;
  logic [8:0]         p_new;
  logic [1:0]         stat;

  function automatic logic [15:0] clamp_width(input logic [15:0] w, input logic [15:0] lo,
                                              input logic [15:0] hi);
    logic [15:0] c;
    if (w < lo) begin
      c = lo;
    end else if (w > hi) begin
      c = hi;
    end else begin
      c = w;
    end
    return c;
  endfunction

  assign width_op = (in_q.opcode == OP_SET_WIDTH) || (in_q.opcode == OP_REAPPLY);
  assign w_sel    = (in_q.opcode == OP_SET_WIDTH) ? in_q.width_request : stored_q;
  assign dev_max  = pot_type_q ? 9'd127 : 9'd256;

  // Offsets for the linear map, taken from the stored width.
  always_comb begin
    x    = clamp_width(stored_q, min_width_q, max_width_q);
    dx   = $signed({1'b0, x}) - $signed({1'b0, min_width_q});
    dpos = $signed({1'b0, max_pos_q}) - $signed({1'b0, min_pos_q});
  end

  // Divider operands in sign and magnitude form.
  always_comb begin
    num_mag = prod_q[26] ? NumWidth'(-prod_q) : NumWidth'(prod_q);
    den_mag = den_q[16] ? DenWidth'(-den_q) : DenWidth'(den_q);
    neg     = prod_q[26] ^ den_q[16];
  end

  pwpw_div #(
    .NumW (NumWidth),
    .DenW (DenWidth)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (num_mag),
    .divisor_i  (den_mag),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  // Truncated quotient plus the lowest position, clamped to the device range.
  always_comb begin
    q_signed = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    r_lin    = q_signed + $signed({19'd0, min_pos_q});
    if (den_q == '0) begin
      p_lin = (min_pos_q > dev_max) ? dev_max : min_pos_q;
    end else if (r_lin < 0) begin
      p_lin = '0;
    end else if (r_lin > $signed({19'd0, dev_max})) begin
      p_lin = dev_max;
    end else begin
      p_lin = r_lin[8:0];
    end
  end

  // Position for the request and the state updates it causes.
  always_comb begin
    p_raw = (in_q.raw_position > {1'b0, dev_max}) ? dev_max : in_q.raw_position[8:0];
    if (in_q.opcode == OP_SET_RAW) begin
      p_new = p_raw;
    end else if (hit_q) begin
      p_new = {2'b00, tval_q};
    end else begin
      p_new = p_lin;
    end

    committed_d  = committed_q;
    known_d      = known_q;
    pend_pos_d   = pend_pos_q;
    pend_valid_d = pend_valid_q;
    good_d       = good_q;
    res_d        = '0;

    if (in_q.opcode == OP_ACK) begin
      if (pend_valid_q) begin
        pend_valid_d = 1'b0;
        good_d       = in_q.ack_ok;
        if (in_q.ack_ok) begin
          committed_d = pend_pos_q;
          known_d     = 1'b1;
        end
      end
      stat = good_d ? STAT_OK : STAT_FAILED;
    end else if (enabled_q && known_q && (committed_q == p_new)) begin
      good_d = 1'b1;
      stat   = STAT_OK;
    end else if (!enabled_q) begin
      good_d = 1'b0;
      stat   = STAT_DISABLED;
    end else begin
      pend_pos_d          = p_new;
      pend_valid_d        = 1'b1;
      res_d.write_needed  = 1'b1;
      res_d.frame_address = bus_addr_q;
      res_d.first_byte    = pot_type_q ? 8'h00 : {7'd0, p_new[8]};
      res_d.second_byte   = p_new[7:0];
      stat                = STAT_WAIT_ACK;
    end

    res_d.status         = stat;
    res_d.position_now   = known_d ? committed_d : '0;
    res_d.position_known = known_d;
    res_d.width_now      = stored_q;
  end

  // Configuration and wiper state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pot_type_q   <= 1'b0;
      min_width_q  <= 16'd1000;
      max_width_q  <= 16'd2000;
      min_pos_q    <= 9'd0;
      max_pos_q    <= 9'd256;
      bus_addr_q   <= 7'd46;
      enabled_q    <= 1'b0;
      committed_q  <= '0;
      known_q      <= 1'b0;
      pend_pos_q   <= '0;
      pend_valid_q <= 1'b0;
      stored_q     <= 16'd1500;
      good_q       <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_item_i.index)
          REG_POT_TYPE:     pot_type_q  <= cfg_item_i.data[0];
          REG_MIN_WIDTH:    min_width_q <= cfg_item_i.data;
          REG_MAX_WIDTH:    max_width_q <= cfg_item_i.data;
          REG_MIN_POSITION: min_pos_q   <= cfg_item_i.data[8:0];
          REG_MAX_POSITION: max_pos_q   <= cfg_item_i.data[8:0];
          REG_BUS_ADDRESS:  bus_addr_q  <= cfg_item_i.data[6:0];
          REG_ENABLED: begin
            enabled_q    <= cfg_item_i.data[0];
            committed_q  <= '0;
            known_q      <= 1'b0;
            pend_valid_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd_i.clamp && width_op) begin
        stored_q <= clamp_width(w_sel, min_width_q, max_width_q);
      end
      if (cmd_i.finish) begin
        committed_q  <= committed_d;
        known_q      <= known_d;
        pend_pos_q   <= pend_pos_d;
        pend_valid_q <= pend_valid_d;
        good_q       <= good_d;
      end
    end
  end

  // Request capture, product, table look-up and finished result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_item_i;
    end
    if (cmd_i.map) begin
      prod_q <= 27'(dx) * 27'(dpos);
      den_q  <= $signed({1'b0, max_width_q}) - $signed({1'b0, min_width_q});
      hit_q  <= pot_type_q && center_hit(stored_q, SYMBOL_COUNT);
      tval_q <= center_value(stored_q);
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  // Output register occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.need_div = width_op && !hit_q && (den_q != '0);
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;

endmodule

>>> design/pwpw_ctrl.sv
// ----------------------------------------------------------------------------
// Pulse width to wiper mapper: controller
// Sequences one request through clamp, map, divide when needed, finish and hand-over.
// ----------------------------------------------------------------------------
module pwpw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pwpw_pkg::dp_status_t status_i,
  output pwpw_pkg::ctrl_cmd_t  cmd_o
);
  import pwpw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP,
    S_MAP,
    S_START,
    S_DIV,
    S_FIN,
    S_HOLD
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = S_MAP;
      end
      S_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = S_START;
      end
      S_START: begin
        if (status_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_HOLD;
      end
      S_HOLD: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // An accepted request always starts with the clamp step.
  a_accept_clamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CLAMP))
    else $error("accepted request did not move to the clamp step");

  // The divider only reports completion while the controller waits for it.
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide step");

  // State is updated exactly once per request.
  a_finish_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (!cmd_o.finish && (state_q == S_HOLD)))
    else $error("finish step repeated");

  // Handing over a result frees the block for the next request.
  a_load_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> in_ready_o)
    else $error("block not ready after result hand-over");

endmodule

>>> sim/pwpw_checker.sv
// ----------------------------------------------------------------------------
// Pulse width to wiper mapper: result checker
// Watches the configuration, request and result channels, keeps its own copy
// of the wiper state, predicts one result per accepted request and compares
// every accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pwpw_checker #(
  parameter int unsigned SymbolCount = pwpw_pkg::SymbolCountDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  pwpw_pkg::in_item_t  req_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  pwpw_pkg::out_item_t res_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  pwpw_pkg::cfg_item_t cfg_i,
  output int                  mismatches_o,
  output int                  outstanding_o
);
  import pwpw_pkg::*;

  // Wiper values for the symbol centres of the seven-bit pot.
  localparam int CentreCount = 18;
  localparam int CentreBase  = 1024;
  localparam int CentreStep  = 56;
  localparam int CentreWiper [CentreCount] = '{
    5, 12, 19, 26, 33, 40, 47, 53, 60, 67, 74, 81, 87, 94, 101, 108, 115, 122
  };

  // Configuration copy.
  logic        pot_type_q;
  logic [15:0] min_width_q;
  logic [15:0] max_width_q;
  logic [8:0]  min_pos_q;
  logic [8:0]  max_pos_q;
  logic [6:0]  bus_addr_q;
  logic        enabled_q;

  // Wiper state copy.
  logic [8:0]  committed_pos_q;
  logic        committed_known_q;
  logic [8:0]  pending_pos_q;
  logic        pending_valid_q;
  logic [15:0] stored_width_q;
  logic        last_good_q;

  out_item_t expected_results [$];
  int        error_count;

  function automatic int wiper_limit();
    return pot_type_q ? 127 : 256;
  endfunction

  function automatic logic [15:0] clamp_width(logic [15:0] w);
    if (w < min_width_q) return min_width_q;
    if (w > max_width_q) return max_width_q;
    return w;
  endfunction

  // Table lookup on a symbol centre, otherwise the truncating linear map.
  function automatic int width_to_wiper(logic [15:0] w);
    int     offset;
    int     k;
    longint x;
    longint in0;
    longint in1;
    longint out0;
    longint out1;
    longint span;
    longint pos;
    if (pot_type_q && w >= CentreBase) begin
      offset = int'(w) - CentreBase;
      if (offset % CentreStep == 0) begin
        k = offset / CentreStep;
        if (k < SymbolCount && k < CentreCount) return CentreWiper[k];
      end
    end
    x    = longint'(clamp_width(w));
    in0  = longint'(min_width_q);
    in1  = longint'(max_width_q);
    out0 = longint'(min_pos_q);
    out1 = longint'(max_pos_q);
    span = in1 - in0;
    if (span == 0) begin
      pos = out0;
    end else begin
      pos = (x - in0) * (out1 - out0) / span + out0;
    end
    if (pos < 0) pos = 0;
    if (pos > wiper_limit()) pos = wiper_limit();
    return int'(pos);
  endfunction

  // Decides whether a frame goes out for the new wiper position.
  function automatic void request_wiper(int p, inout out_item_t res);
    logic [8:0] pos;
    if (p > wiper_limit()) p = wiper_limit();
    pos = 9'(p);
    if (enabled_q && committed_known_q && committed_pos_q == pos) begin
      last_good_q = 1'b1;
      res.status  = STAT_OK;
      return;
    end
    if (!enabled_q) begin
      last_good_q = 1'b0;
      res.status  = STAT_DISABLED;
      return;
    end
    pending_pos_q     = pos;
    pending_valid_q   = 1'b1;
    res.write_needed  = 1'b1;
    res.frame_address = bus_addr_q;
    res.first_byte    = pot_type_q ? 8'h00 : {7'd0, pos[8]};
    res.second_byte   = pos[7:0];
    res.status        = STAT_WAIT_ACK;
  endfunction

  function automatic out_item_t predict_wiper_result(in_item_t req);
    out_item_t   res;
    logic [15:0] w;
    res = '0;
    case (opcode_e'(req.opcode))
      OP_SET_WIDTH, OP_REAPPLY: begin
        w = (opcode_e'(req.opcode) == OP_SET_WIDTH) ? req.width_request : stored_width_q;
        stored_width_q = clamp_width(w);
        request_wiper(width_to_wiper(stored_width_q), res);
      end
      OP_SET_RAW: begin
        request_wiper(int'(req.raw_position), res);
      end
      default: begin
        // Acknowledge report: only acts on a write that is still pending.
        if (pending_valid_q) begin
          pending_valid_q = 1'b0;
          last_good_q     = req.ack_ok;
          if (req.ack_ok) begin
            committed_pos_q   = pending_pos_q;
            committed_known_q = 1'b1;
          end
        end
        res.status = last_good_q ? STAT_OK : STAT_FAILED;
      end
    endcase
    res.position_now   = committed_known_q ? committed_pos_q : 9'd0;
    res.position_known = committed_known_q;
    res.width_now      = stored_width_q;
    return res;
  endfunction

  function automatic void write_setting(cfg_item_t cfg);
    case (reg_index_e'(cfg.index))
      REG_POT_TYPE:     pot_type_q  = cfg.data[0];
      REG_MIN_WIDTH:    min_width_q = cfg.data;
      REG_MAX_WIDTH:    max_width_q = cfg.data;
      REG_MIN_POSITION: min_pos_q   = cfg.data[8:0];
      REG_MAX_POSITION: max_pos_q   = cfg.data[8:0];
      REG_BUS_ADDRESS:  bus_addr_q  = cfg.data[6:0];
      REG_ENABLED: begin
        enabled_q         = cfg.data[0];
        committed_known_q = 1'b0;
        committed_pos_q   = '0;
        pending_valid_q   = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      error_count++;
      $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      error_count++;
      $display("%0t: result with no request outstanding: expected none, actual %h",
               $time, got);
      return;
    end
    want = expected_results.pop_front();
    check_field("write_needed",   want.write_needed,   got.write_needed);
    check_field("frame_address",  want.frame_address,  got.frame_address);
    check_field("first_byte",     want.first_byte,     got.first_byte);
    check_field("second_byte",    want.second_byte,    got.second_byte);
    check_field("status",         want.status,         got.status);
    check_field("position_now",   want.position_now,   got.position_now);
    check_field("position_known", want.position_known, got.position_known);
    check_field("width_now",      want.width_now,      got.width_now);
  endfunction

  // Track every handshake; the state copy follows the block request by request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pot_type_q        = 1'b0;
      min_width_q       = 16'd1000;
      max_width_q       = 16'd2000;
      min_pos_q         = 9'd0;
      max_pos_q         = 9'd256;
      bus_addr_q        = 7'd46;
      enabled_q         = 1'b0;
      committed_pos_q   = '0;
      committed_known_q = 1'b0;
      pending_pos_q     = '0;
      pending_valid_q   = 1'b0;
      stored_width_q    = 16'd1500;
      last_good_q       = 1'b0;
      error_count       = 0;
      expected_results.delete();
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_setting(cfg_i);
      if (req_valid_i && req_ready_i) expected_results.push_back(predict_wiper_result(req_i));
      if (res_valid_i && res_ready_i) check_result(res_i);
      mismatches_o  <= error_count;
      outstanding_o <= expected_results.size();
    end
  end

endmodule

>>> sim/tb_pulse_width_to_pot_wiper_unit.sv
// ----------------------------------------------------------------------------
// Pulse width to wiper mapper: testbench
// Drives directed and random requests under several calibration settings and
// idling patterns; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_pulse_width_to_pot_wiper_unit;
  import pwpw_pkg::*;

  localparam int CycleLimit     = 400000;
  localparam int DrainCycles    = 8;
  localparam int PhaseCount     = 10;
  localparam int RequestsPerPhase = 75;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    bit pot_type;
    int min_width;
    int max_width;
    int min_pos;
    int max_pos;
    int bus_addr;
    bit enabled;
  } wiper_setup_t;

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;
  int   mismatches;
  int   outstanding;

  // Stimulus shaping follows the current calibration.
  wiper_setup_t setup_now;
  logic [15:0]  last_width = 16'd1500;
  bit           last_was_write = 1'b0;

  pwpw_chan_if #(.payload_t(in_item_t))  req_if ();
  pwpw_chan_if #(.payload_t(out_item_t)) res_if ();
  pwpw_chan_if #(.payload_t(cfg_item_t)) cfg_if ();

  pulse_width_to_pot_wiper_unit u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  pwpw_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_valid_i   (req_if.valid),
    .req_ready_i   (req_if.ready),
    .req_i         (req_if.payload),
    .res_valid_i   (res_if.valid),
    .res_ready_i   (res_if.ready),
    .res_i         (res_if.payload),
    .cfg_valid_i   (cfg_if.valid),
    .cfg_ready_i   (cfg_if.ready),
    .cfg_i         (cfg_if.payload),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls at random according to the current idling pattern.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void set_idle_mode(idle_mode_e mode);
    case (mode)
      IDLE_SENDER:   begin gap_pct = 52; stall_pct = 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 52; end
      IDLE_BOTH:     begin gap_pct = 34; stall_pct = 34; end
      default:       begin gap_pct = 0;  stall_pct = 0;  end
    endcase
  endfunction

  // Valid stays high from one request to the next unless a gap is drawn.
  task automatic send_request(input in_item_t req);
    while ($urandom_range(0, 99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= req;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic send_op(opcode_e op, int w, int p, bit ok);
    in_item_t req;
    req.opcode        = op;
    req.width_request = 16'(w);
    req.raw_position  = 10'(p);
    req.ack_ok        = ok;
    send_request(req);
  endtask

  // Waits until every predicted result has been taken by the receiver.
  task automatic drain_requests();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_e idx, int data);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= {idx, 16'(data)};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  // Writes every register; enabled goes last since it clears the wiper state.
  task automatic apply_setup(wiper_setup_t s);
    setup_now = s;
    write_reg(REG_POT_TYPE,     s.pot_type);
    write_reg(REG_MIN_WIDTH,    s.min_width);
    write_reg(REG_MAX_WIDTH,    s.max_width);
    write_reg(REG_MIN_POSITION, s.min_pos);
    write_reg(REG_MAX_POSITION, s.max_pos);
    write_reg(REG_BUS_ADDRESS,  s.bus_addr);
    write_reg(REG_ENABLED,      s.enabled);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic wiper_setup_t random_setup();
    wiper_setup_t s;
    s.pot_type  = $urandom_range(0, 1);
    s.min_width = $urandom_range(0, 65535);
    s.max_width = $urandom_range(0, 65535);
    s.min_pos   = $urandom_range(0, 256);
    s.max_pos   = $urandom_range(0, 256);
    s.bus_addr  = $urandom_range(0, 127);
    s.enabled   = ($urandom_range(0, 7) != 0);
    return s;
  endfunction

  // Mostly width requests followed by their acknowledge, with noise mixed in.
  function automatic in_item_t random_request();
    in_item_t req;
    int       pick;
    int       lo;
    int       hi;
    req.width_request = 16'($urandom);
    req.raw_position  = 10'($urandom);
    req.ack_ok        = ($urandom_range(0, 3) != 0);
    pick = $urandom_range(0, 99);
    if (last_was_write && $urandom_range(0, 1) == 1) begin
      req.opcode = OP_ACK;
    end else if (pick < 35) begin
      req.opcode = OP_SET_WIDTH;
    end else if (pick < 50) begin
      req.opcode = OP_SET_RAW;
    end else if (pick < 85) begin
      req.opcode = OP_ACK;
    end else begin
      req.opcode = OP_REAPPLY;
    end
    lo   = setup_now.min_width;
    hi   = setup_now.max_width;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      req.width_request = 16'(1024 + 56 * $urandom_range(0, 20));
    end else if (pick < 50) begin
      req.width_request = 16'($urandom_range(lo, hi));
    end else if (pick < 60) begin
      req.width_request = last_width;
    end else if (pick < 70) begin
      req.width_request = 16'(($urandom_range(0, 1) ? lo : hi) + $urandom_range(0, 2) - 1);
    end
    if ($urandom_range(0, 1) == 1) begin
      req.raw_position = 10'($urandom_range(0, setup_now.pot_type ? 127 : 256));
    end
    if (opcode_e'(req.opcode) == OP_SET_WIDTH) last_width = req.width_request;
    last_was_write = (opcode_e'(req.opcode) != OP_ACK);
    return req;
  endfunction

  initial begin
    wiper_setup_t fixed_setups [8];
    wiper_setup_t s;

    fixed_setups[0] = '{1'b0, 1000, 2000, 0, 256, 46, 1'b1};
    fixed_setups[1] = '{1'b1, 1000, 2000, 0, 127, 85, 1'b1};
    fixed_setups[2] = '{1'b0, 0, 65535, 256, 0, 127, 1'b1};
    fixed_setups[3] = '{1'b1, 900, 3000, 10, 120, 0, 1'b1};
    fixed_setups[4] = '{1'b0, 1500, 1500, 100, 200, 1, 1'b1};
    fixed_setups[5] = '{1'b1, 2000, 1000, 256, 0, 42, 1'b1};
    fixed_setups[6] = '{1'b0, 65535, 0, 0, 256, 99, 1'b1};
    fixed_setups[7] = '{1'b0, 1000, 2000, 0, 256, 46, 1'b0};

    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    setup_now      = '{1'b0, 1000, 2000, 0, 256, 46, 1'b0};
    set_idle_mode(IDLE_NONE);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset the device is not enabled; a lone acknowledge reports failure.
    send_op(OP_SET_WIDTH, 1500, 0, 1'b1);
    send_op(OP_ACK, 0, 0, 1'b1);
    send_op(OP_REAPPLY, 0, 0, 1'b0);
    drain_requests();

    // Width extremes, replaced requests, failed and stray acknowledges.
    apply_setup(fixed_setups[0]);
    send_op(OP_SET_WIDTH, 0, 0, 1'b0);
    send_op(OP_ACK, 0, 0, 1'b1);
    send_op(OP_SET_WIDTH, 65535, 0, 1'b0);
    send_op(OP_SET_WIDTH, 999, 0, 1'b0);
    send_op(OP_ACK, 0, 0, 1'b0);
    send_op(OP_ACK, 0, 0, 1'b1);
    send_op(OP_SET_RAW, 0, 1023, 1'b0);
    send_op(OP_SET_RAW, 0, 0, 1'b0);
    send_op(OP_ACK, 0, 0, 1'b1);
    send_op(OP_ACK, 0, 0, 1'b1);
    send_op(OP_REAPPLY, 0, 512, 1'b0);
    send_op(OP_SET_WIDTH, 1234, 0, 1'b0);
    send_op(OP_SET_RAW, 0, 512, 1'b1);
    drain_requests();

    // Seven-bit pot: first and last table centre, a centre past the table.
    s = '{1'b1, 1000, 3000, 0, 256, 85, 1'b1};
    apply_setup(s);
    send_op(OP_SET_WIDTH, 1024, 0, 1'b0);
    send_op(OP_SET_WIDTH, 1976, 0, 1'b0);
    send_op(OP_SET_WIDTH, 2032, 0, 1'b0);
    send_op(OP_SET_WIDTH, 1025, 0, 1'b0);
    send_op(OP_SET_RAW, 0, 200, 1'b0);
    send_op(OP_ACK, 0, 0, 1'b1);
    drain_requests();

    // Equal and then inverted calibration widths.
    s = '{1'b0, 1500, 1500, 7, 200, 3, 1'b1};
    apply_setup(s);
    send_op(OP_SET_WIDTH, 1500, 0, 1'b0);
    send_op(OP_SET_WIDTH, 65535, 0, 1'b0);
    drain_requests();
    s = '{1'b0, 2000, 1000, 256, 0, 64, 1'b1};
    apply_setup(s);
    send_op(OP_SET_WIDTH, 1500, 0, 1'b0);
    send_op(OP_SET_WIDTH, 0, 0, 1'b0);
    drain_requests();

    // Random phases, each with its own calibration and idling pattern.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      s = (ph < 8) ? fixed_setups[ph] : random_setup();
      apply_setup(s);
      set_idle_mode(idle_mode_e'(ph % 4));
      last_was_write = 1'b0;
      for (int n = 0; n < RequestsPerPhase; n++) begin
        send_request(random_request());
      end
      drain_requests();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
